// File: rtl/efl_pkg.sv
// Shared constants and types for the extent free-list allocator.
// No dependencies; every other file imports this package.
package efl_pkg;

	localparam int MAX_EXTENTS_DEF = 32;
	localparam int ITEM_BITS_DEF   = 16;
	localparam longint unsigned RESET_COUNT = 64'd65536;

	typedef logic [2:0] status_t;

	localparam status_t ST_OK           = 3'd0;
	localparam status_t ST_EMPTY        = 3'd1;
	localparam status_t ST_ALREADY_FREE = 3'd2;
	localparam status_t ST_OUT_OF_RANGE = 3'd3;
	localparam status_t ST_TABLE_FULL   = 3'd4;

endpackage

// File: rtl/efl_req_if.sv
// Request channel of the extent free-list allocator: allocate or free one item.
// Depends on efl_pkg.
interface efl_req_if
	import efl_pkg::*;
#(
	parameter int ITEM_BITS = ITEM_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic                 kind;
	logic [ITEM_BITS-1:0] item;

	modport source (output valid, output kind, output item, input ready);
	modport sink   (input valid, input kind, input item, output ready);
endinterface

// File: rtl/efl_rsp_if.sv
// Result channel of the extent free-list allocator: granted item, status, last extent start.
// Depends on efl_pkg.
interface efl_rsp_if
	import efl_pkg::*;
#(
	parameter int ITEM_BITS = ITEM_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic [ITEM_BITS-1:0] granted_item;
	status_t              status;
	logic [ITEM_BITS:0]   last_extent_start;

	modport source (output valid, output granted_item, output status,
		output last_extent_start, input ready);
	modport sink   (input valid, input granted_item, input status,
		input last_extent_start, output ready);
endinterface

// File: rtl/extent_free_list_allocator.sv
// Extent free-list allocator: sorted table of free extents in one dual-port memory.
// Depends on efl_pkg, efl_req_if and efl_rsp_if.
//
//   channel  | role | transaction
//   ---------+------+-------------------------------------------------------
//   req      | sink | kind (0 alloc, 1 free), item
//   rsp      | src  | granted_item, status, last_extent_start (one per req)
//   cfg      | in   | cfg_we/cfg_wdata: item_count, resets the table
//
// Allocate reads the first extent and shrinks it; when it empties, the later entries shift down.
// Free scans the extents in order, checks a join with the next extent when it grows one upward,
// and shifts entries when one is inserted or dropped (only a new entry is written when none
// move). Reset or an item_count write sets the table at once: entry 0 comes from a flag until
// first written, so there is no clearing pass.
// A new request is taken while the previous result waits; a stalled output holds the engine.
module extent_free_list_allocator
	import efl_pkg::*;
#(
	parameter int MAX_EXTENTS = MAX_EXTENTS_DEF,
	parameter int ITEM_BITS   = ITEM_BITS_DEF
)(
	input  logic             clk,
	input  logic             arst_n,
	efl_req_if.sink          req,
	efl_rsp_if.source        rsp,
	input  logic             cfg_we,
	input  logic [ITEM_BITS:0] cfg_wdata
);

	localparam int IDX_W = $clog2(MAX_EXTENTS);
	localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
	localparam int LEN_W = ITEM_BITS + 1;

	localparam logic [LEN_W-1:0] LIMIT   = {1'b1, {ITEM_BITS{1'b0}}};
	localparam logic [LEN_W-1:0] RST_CNT =
		(RESET_COUNT > (64'd1 << ITEM_BITS)) ? LIMIT :
		(RESET_COUNT == 64'd0) ? LEN_W'(1) : LEN_W'(RESET_COUNT);
	localparam logic [CNT_W-1:0] FULL    = CNT_W'(MAX_EXTENTS);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ALLOC = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_JOIN  = 3'd3;
	localparam logic [2:0] S_MOVE  = 3'd4;
	localparam logic [2:0] S_LAST  = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	typedef struct packed {
		logic [ITEM_BITS-1:0] start;
		logic [LEN_W-1:0]     len;
	} entry_t;

	function automatic logic [LEN_W-1:0] clamp_count(input logic [LEN_W-1:0] v);
		logic [LEN_W-1:0] r;
		r = v;
		if (v == '0)
			r = LEN_W'(1);
		else if (v > LIMIT)
			r = LIMIT;
		return r;
	endfunction

	entry_t ext_mem_q [MAX_EXTENTS];
	entry_t rd_data_q;

	logic [2:0]           state_q;
	logic [LEN_W-1:0]     icnt_q;
	logic [CNT_W-1:0]     count_q;
	logic                 init_q;
	logic [ITEM_BITS-1:0] item_q;
	logic [ITEM_BITS-1:0] granted_q;
	status_t              status_q;
	logic [IDX_W-1:0]     i_q;
	entry_t               prev_q;
	entry_t               cur_q;
	logic                 mv_dir_q;
	logic [IDX_W-1:0]     src_q;
	logic [CNT_W-1:0]     mv_n_q;
	logic                 mv_v_q;
	logic [IDX_W-1:0]     mv_dst_q;
	logic [IDX_W-1:0]     ins_pos_q;
	logic                 out_valid_q;
	logic [ITEM_BITS-1:0] out_granted_q;
	status_t              out_status_q;
	logic [LEN_W-1:0]     out_last_q;

	logic             in_acc;
	logic             out_load;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;

	logic [LEN_W-1:0] item_x;
	logic [LEN_W-1:0] item_p1;
	logic [LEN_W-1:0] d_start_x;
	logic [LEN_W-1:0] d_end;
	logic [LEN_W-1:0] prev_end;
	logic [LEN_W-1:0] cur_end;
	logic [CNT_W-1:0] i_p1;
	logic             c_before;
	logic             c_touch_lo;
	logic             c_inside;
	logic             c_touch_hi;
	logic             prev_merge;
	logic             next_merge;
	logic             last_i;
	logic             full;

	assign req.ready = (state_q == S_IDLE);
	assign in_acc    = req.valid && req.ready;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	assign rsp.valid             = out_valid_q;
	assign rsp.granted_item      = out_granted_q;
	assign rsp.status            = out_status_q;
	assign rsp.last_extent_start = out_last_q;

	// extent compare against the entry that just came out of memory
	always_comb begin
		item_x     = {1'b0, item_q};
		item_p1    = item_x + LEN_W'(1);
		d_start_x  = {1'b0, rd_data_q.start};
		d_end      = d_start_x + rd_data_q.len;
		prev_end   = {1'b0, prev_q.start} + prev_q.len;
		cur_end    = {1'b0, cur_q.start} + cur_q.len;
		i_p1       = CNT_W'(i_q) + CNT_W'(1);
		c_before   = item_p1 < d_start_x;
		c_touch_lo = item_p1 == d_start_x;
		c_inside   = item_x < d_end;
		c_touch_hi = item_x == d_end;
		prev_merge = (i_q != '0) && (prev_end == item_x);
		next_merge = cur_end == d_start_x;
		last_i     = i_p1 == count_q;
		full       = count_q == FULL;
	end

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && count_q != '0 &&
					(!req.kind || {1'b0, req.item} < icnt_q)) begin
					rd_en = 1'b1;
				end
			end
			S_ALLOC: begin
				if (rd_data_q.len != LEN_W'(1)) begin
					wr_en   = 1'b1;
					wr_data = '{start: rd_data_q.start + ITEM_BITS'(1),
						len: rd_data_q.len - LEN_W'(1)};
				end
			end
			S_SCAN: begin
				// fetch the next entry ahead; it serves the join check too
				rd_en   = !last_i;
				rd_addr = IDX_W'(i_p1);
				priority if (c_before) begin
				end else if (c_touch_lo) begin
					wr_en = 1'b1;
					if (prev_merge) begin
						wr_addr = i_q - IDX_W'(1);
						wr_data = '{start: prev_q.start,
							len: prev_q.len + rd_data_q.len + LEN_W'(1)};
					end else begin
						wr_addr = i_q;
						wr_data = '{start: item_q, len: rd_data_q.len + LEN_W'(1)};
					end
				end else if (c_inside) begin
				end else if (c_touch_hi) begin
					if (last_i) begin
						wr_en   = 1'b1;
						wr_addr = i_q;
						wr_data = '{start: rd_data_q.start,
							len: rd_data_q.len + LEN_W'(1)};
					end
				end else begin
				end
			end
			S_JOIN: begin
				wr_en   = 1'b1;
				wr_addr = i_q;
				wr_data = next_merge ?
					entry_t'{start: cur_q.start, len: cur_q.len + rd_data_q.len} : cur_q;
			end
			S_MOVE: begin
				if (mv_v_q) begin
					wr_en   = 1'b1;
					wr_addr = mv_dst_q;
					wr_data = rd_data_q;
				end else if (mv_n_q == '0 && mv_dir_q) begin
					wr_en   = 1'b1;
					wr_addr = ins_pos_q;
					wr_data = '{start: item_q, len: LEN_W'(1)};
				end
				if (mv_n_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = src_q;
				end
			end
			S_LAST: begin
				rd_en   = 1'b1;
				rd_addr = IDX_W'(count_q - CNT_W'(1));
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// extent table; entry 0 comes from the init flag until first written
	always_ff @(posedge clk) begin
		if (wr_en)
			ext_mem_q[wr_addr] <= wr_data;
		if (rd_en) begin
			if (init_q && rd_addr == '0)
				rd_data_q <= '{start: '0, len: icnt_q};
			else
				rd_data_q <= ext_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			icnt_q      <= RST_CNT;
			count_q     <= CNT_W'(1);
			init_q      <= 1'b1;
			mv_v_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en && wr_addr == '0)
				init_q <= 1'b0;
			if (out_valid_q && rsp.ready && !out_load)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						item_q    <= req.item;
						granted_q <= '0;
						status_q  <= ST_OK;
						i_q       <= '0;
						if (!req.kind) begin
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
								state_q  <= S_LAST;
							end else begin
								state_q <= S_ALLOC;
							end
						end else if ({1'b0, req.item} >= icnt_q) begin
							status_q <= ST_OUT_OF_RANGE;
							state_q  <= S_LAST;
						end else if (count_q == '0) begin
							mv_dir_q  <= 1'b1;
							mv_n_q    <= '0;
							ins_pos_q <= '0;
							state_q   <= S_MOVE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_ALLOC: begin
					granted_q <= rd_data_q.start;
					if (rd_data_q.len == LEN_W'(1)) begin
						// first extent emptied: drop it
						mv_dir_q <= 1'b0;
						src_q    <= IDX_W'(1);
						mv_n_q   <= count_q - CNT_W'(1);
						state_q  <= S_MOVE;
					end else begin
						state_q <= S_LAST;
					end
				end
				S_SCAN: begin
					priority if (c_before) begin
						if (full) begin
							status_q <= ST_TABLE_FULL;
							state_q  <= S_LAST;
						end else begin
							mv_dir_q  <= 1'b1;
							src_q     <= IDX_W'(count_q - CNT_W'(1));
							mv_n_q    <= count_q - CNT_W'(i_q);
							ins_pos_q <= i_q;
							state_q   <= S_MOVE;
						end
					end else if (c_touch_lo) begin
						if (prev_merge) begin
							mv_dir_q <= 1'b0;
							src_q    <= IDX_W'(i_p1);
							mv_n_q   <= count_q - i_p1;
							state_q  <= S_MOVE;
						end else begin
							state_q <= S_LAST;
						end
					end else if (c_inside) begin
						status_q <= ST_ALREADY_FREE;
						state_q  <= S_LAST;
					end else if (c_touch_hi) begin
						if (last_i) begin
							state_q <= S_LAST;
						end else begin
							cur_q   <= '{start: rd_data_q.start,
								len: rd_data_q.len + LEN_W'(1)};
							state_q <= S_JOIN;
						end
					end else begin
						prev_q <= rd_data_q;
						if (last_i) begin
							if (full) begin
								status_q <= ST_TABLE_FULL;
								state_q  <= S_LAST;
							end else begin
								mv_dir_q  <= 1'b1;
								mv_n_q    <= '0;
								ins_pos_q <= IDX_W'(count_q);
								state_q   <= S_MOVE;
							end
						end else begin
							i_q <= i_q + IDX_W'(1);
						end
					end
				end
				S_JOIN: begin
					if (next_merge) begin
						mv_dir_q <= 1'b0;
						src_q    <= IDX_W'(i_p1 + CNT_W'(1));
						mv_n_q   <= count_q - i_p1 - CNT_W'(1);
						state_q  <= S_MOVE;
					end else begin
						state_q <= S_LAST;
					end
				end
				S_MOVE: begin
					if (mv_n_q != '0) begin
						mv_v_q   <= 1'b1;
						mv_n_q   <= mv_n_q - CNT_W'(1);
						src_q    <= mv_dir_q ? src_q - IDX_W'(1) : src_q + IDX_W'(1);
						mv_dst_q <= mv_dir_q ? src_q + IDX_W'(1) : src_q - IDX_W'(1);
					end else begin
						mv_v_q <= 1'b0;
						if (!mv_v_q) begin
							count_q <= mv_dir_q ? count_q + CNT_W'(1) : count_q - CNT_W'(1);
							state_q <= S_LAST;
						end
					end
				end
				S_LAST: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						out_valid_q   <= 1'b1;
						out_granted_q <= granted_q;
						out_status_q  <= status_q;
						out_last_q    <= (count_q != '0) ? {1'b0, rd_data_q.start} : icnt_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (cfg_we) begin
				icnt_q  <= clamp_count(cfg_wdata);
				count_q <= CNT_W'(1);
				init_q  <= 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("extent count above table size");

	a_port_conflict: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (rd_addr != wr_addr))
		else $error("memory read and write hit the same entry");

	a_empty_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !req.kind && count_q == '0 && !cfg_we) |=> (status_q == ST_EMPTY))
		else $error("allocate on empty table not flagged");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && status_q == ST_TABLE_FULL) |-> (count_q == FULL))
		else $error("table_full reported with room left");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOVE && mv_dir_q && mv_n_q == '0 && !mv_v_q) |-> (count_q < FULL))
		else $error("insert into a full table");

endmodule

// File: sim/tb_extent_free_list_allocator.sv
// Self-checking testbench for extent_free_list_allocator: request and result channels
// with random idling on both sides, item_count writes between phases, scoreboarded results.
// Depends on efl_pkg, efl_req_if, efl_rsp_if and the RTL top level.
module tb_extent_free_list_allocator;
	import efl_pkg::*;

	localparam int MAX_EXT = MAX_EXTENTS_DEF;
	localparam int ITEM_W = ITEM_BITS_DEF;
	localparam logic [ITEM_W:0] POOL_LIMIT = {1'b1, {ITEM_W{1'b0}}};
	localparam logic [ITEM_W:0] RUN_ONE = {{ITEM_W{1'b0}}, 1'b1};
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE = 1'b1;
	localparam int LONG_HOLD = 100;
	localparam int DRAIN_CYCLES = 100;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic              kind;
		logic [ITEM_W-1:0] item;
	} req_t;

	typedef struct packed {
		logic [ITEM_W-1:0] granted;
		status_t           status;
		logic [ITEM_W:0]   tail_start;
	} outcome_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ITEM_W:0] cfg_wdata;

	efl_req_if #(.ITEM_BITS(ITEM_W)) req_ch ();
	efl_rsp_if #(.ITEM_BITS(ITEM_W)) rsp_ch ();

	extent_free_list_allocator #(
		.MAX_EXTENTS(MAX_EXT),
		.ITEM_BITS(ITEM_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// shadow of the free-extent table
	logic [ITEM_W:0] pool_size;
	logic [ITEM_W:0] run_base [MAX_EXT];
	logic [ITEM_W:0] run_len [MAX_EXT];
	int run_cnt;

	req_t requests_to_send [$];
	outcome_t outcomes_due [$];
	int items_sent = 0;
	int results_seen = 0;
	int fail_count = 0;
	bit gaps_on = 1'b1;
	logic req_taken = 1'b0;
	int tx_gap = 0;
	int rx_gap = 0;
	int hold_left = 0;
	int holds_asked = 0;
	int holds_served = 0;

	function automatic logic [ITEM_W:0] clamp_pool(logic [ITEM_W:0] v);
		if (v == '0)
			return RUN_ONE;
		if (v > POOL_LIMIT)
			return POOL_LIMIT;
		return v;
	endfunction

	function automatic void reset_table();
		run_base[0] = '0;
		run_len[0] = pool_size;
		run_cnt = 1;
	endfunction

	function automatic void drop_run(int pos);
		for (int k = pos; k + 1 < run_cnt; k++) begin
			run_base[k] = run_base[k + 1];
			run_len[k] = run_len[k + 1];
		end
		run_cnt--;
	endfunction

	function automatic void join_next(int pos);
		if (pos + 1 >= run_cnt)
			return;
		if (run_base[pos] + run_len[pos] == run_base[pos + 1]) begin
			run_len[pos] = run_len[pos] + run_len[pos + 1];
			drop_run(pos + 1);
		end
	endfunction

	// Advance the shadow table by one request and return the result it must produce.
	function automatic outcome_t apply_request(logic kind, logic [ITEM_W-1:0] item);
		outcome_t o;
		logic [ITEM_W:0] it;
		logic [ITEM_W:0] top;
		int slot;
		bit scanning;
		bit need_new;
		o.granted = '0;
		o.status = ST_OK;
		it = {1'b0, item};
		if (kind == KIND_ALLOC) begin
			if (run_cnt == 0) begin
				o.status = ST_EMPTY;
			end else begin
				o.granted = run_base[0][ITEM_W-1:0];
				run_base[0] = run_base[0] + RUN_ONE;
				run_len[0] = run_len[0] - RUN_ONE;
				if (run_len[0] == '0)
					drop_run(0);
			end
		end else if (it >= pool_size) begin
			o.status = ST_OUT_OF_RANGE;
		end else begin
			scanning = 1'b1;
			need_new = 1'b1;
			slot = run_cnt;
			for (int i = 0; i < run_cnt && scanning; i++) begin
				top = run_base[i] + run_len[i];
				if (it + RUN_ONE < run_base[i]) begin
					slot = i;
					scanning = 1'b0;
				end else if (it + RUN_ONE == run_base[i]) begin
					// grow downward, then check the gap to the previous extent
					run_base[i] = it;
					run_len[i] = run_len[i] + RUN_ONE;
					if (i > 0)
						join_next(i - 1);
					need_new = 1'b0;
					scanning = 1'b0;
				end else if (it < top) begin
					o.status = ST_ALREADY_FREE;
					need_new = 1'b0;
					scanning = 1'b0;
				end else if (it == top) begin
					run_len[i] = run_len[i] + RUN_ONE;
					join_next(i);
					need_new = 1'b0;
					scanning = 1'b0;
				end
			end
			if (need_new) begin
				if (run_cnt >= MAX_EXT) begin
					o.status = ST_TABLE_FULL;
				end else begin
					for (int k = run_cnt; k > slot; k--) begin
						run_base[k] = run_base[k - 1];
						run_len[k] = run_len[k - 1];
					end
					run_base[slot] = it;
					run_len[slot] = RUN_ONE;
					run_cnt++;
				end
			end
		end
		o.tail_start = (run_cnt != 0) ? run_base[run_cnt - 1] : pool_size;
		return o;
	endfunction

	task automatic note_failure(string what);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch: %s", what);
	endtask

	task automatic queue_req(logic kind, int unsigned item);
		req_t r;
		r.kind = kind;
		r.item = item[ITEM_W-1:0];
		requests_to_send.insert(requests_to_send.size(), r);
		items_sent++;
	endtask

	task automatic wait_idle();
		while (results_seen < items_sent)
			@(negedge clk);
	endtask

	// Write item_count only once every outstanding result is back.
	task automatic write_pool_size(int unsigned v);
		wait_idle();
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v[ITEM_W:0];
		pool_size = clamp_pool(v[ITEM_W:0]);
		reset_table();
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic queue_frees_shuffled(int first, int n);
		int picks [$];
		int j;
		int t;
		for (int k = 0; k < n; k++)
			picks.insert(picks.size(), first + 2 * k);
		for (int k = n - 1; k > 0; k--) begin
			j = $urandom_range(0, k);
			t = picks[k];
			picks[k] = picks[j];
			picks[j] = t;
		end
		foreach (picks[k])
			queue_req(KIND_FREE, picks[k]);
	endtask

	task automatic queue_churn(int n, int span, int alloc_pct);
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < alloc_pct)
				queue_req(KIND_ALLOC, $urandom);
			else if (r < alloc_pct + (100 - alloc_pct) * 4 / 5)
				queue_req(KIND_FREE, $urandom_range(0, span - 1));
			else
				queue_req(KIND_FREE, $urandom);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// request driver
	always @(negedge clk) begin
		req_t next_req;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.kind <= KIND_ALLOC;
			req_ch.item <= '0;
		end else if (req_ch.valid && !req_taken) begin
			// hold until the transaction goes through
		end else if (tx_gap > 0) begin
			tx_gap <= tx_gap - 1;
			req_ch.valid <= 1'b0;
		end else if (requests_to_send.size() != 0 && gaps_on && $urandom_range(0, 7) == 0) begin
			tx_gap <= $urandom_range(0, 11);
			req_ch.valid <= 1'b0;
		end else if (requests_to_send.size() != 0) begin
			next_req = requests_to_send[0];
			requests_to_send.delete(0);
			req_ch.valid <= 1'b1;
			req_ch.kind <= next_req.kind;
			req_ch.item <= next_req.item;
		end else begin
			req_ch.valid <= 1'b0;
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_ch.ready <= 1'b0;
		end else if (holds_served != holds_asked) begin
			holds_served <= holds_served + 1;
			hold_left <= LONG_HOLD - 1;
			rsp_ch.ready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap <= rx_gap - 1;
			rsp_ch.ready <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 7) == 0) begin
			rx_gap <= $urandom_range(0, 11);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// monitor and scoreboard
	always @(posedge clk) begin
		outcome_t want;
		req_taken <= req_ch.valid && req_ch.ready;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				outcomes_due.insert(outcomes_due.size(),
					apply_request(req_ch.kind, req_ch.item));
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_seen++;
				if (outcomes_due.size() == 0) begin
					note_failure($sformatf("unexpected result: item %0d status %0d tail %0d",
						rsp_ch.granted_item, rsp_ch.status, rsp_ch.last_extent_start));
				end else begin
					want = outcomes_due[0];
					outcomes_due.delete(0);
					if (rsp_ch.granted_item !== want.granted || rsp_ch.status !== want.status ||
							rsp_ch.last_extent_start !== want.tail_start)
						note_failure($sformatf(
							"expected item %0d status %0d tail %0d, got item %0d status %0d tail %0d",
							want.granted, want.status, want.tail_start, rsp_ch.granted_item,
							rsp_ch.status, rsp_ch.last_extent_start));
				end
			end
		end
	end

	// end the run when nothing moves for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int pool_n;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		pool_size = clamp_pool(RESET_COUNT[ITEM_W:0]);
		reset_table();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full pool after reset: grants from the front, merges back to one extent
		queue_req(KIND_ALLOC, 16'hFFFF);
		queue_req(KIND_ALLOC, 0);
		queue_req(KIND_FREE, 16'hFFFF);
		queue_req(KIND_FREE, 0);
		queue_req(KIND_FREE, 0);
		queue_req(KIND_FREE, 1);
		queue_req(KIND_ALLOC, 0);
		queue_req(KIND_FREE, 16'hAAAA);
		queue_req(KIND_FREE, 16'h5555);

		// zero written, taken as a pool of one
		write_pool_size(0);
		queue_req(KIND_ALLOC, 0);
		queue_req(KIND_ALLOC, 0);
		queue_req(KIND_FREE, 1);
		queue_req(KIND_FREE, 16'hFFFF);
		queue_req(KIND_FREE, 0);
		queue_req(KIND_FREE, 0);

		// drain a pool of four, then rebuild it out of order
		write_pool_size(4);
		repeat (5) queue_req(KIND_ALLOC, 0);
		queue_req(KIND_FREE, 3);
		queue_req(KIND_FREE, 1);
		queue_req(KIND_FREE, 2);
		queue_req(KIND_FREE, 0);
		queue_req(KIND_FREE, 4);

		// oversized write limits to the full item space
		write_pool_size(17'h1FFFF);
		queue_req(KIND_ALLOC, 0);
		queue_req(KIND_FREE, 16'hFFFF);

		// fragment the pool past the table size, then knit it back together
		pool_n = $urandom_range(66, 90);
		write_pool_size(pool_n);
		for (int k = 0; k <= pool_n; k++)
			queue_req(KIND_ALLOC, $urandom);
		holds_asked++;
		queue_frees_shuffled(0, (pool_n + 1) / 2);
		queue_frees_shuffled(1, pool_n / 2);
		repeat (12) queue_req(KIND_FREE, $urandom_range(0, pool_n - 1));
		queue_req(KIND_FREE, $urandom_range(pool_n, 65535));

		pool_n = $urandom_range(2, 40);
		write_pool_size(pool_n);
		holds_asked++;
		queue_churn(100, pool_n + 2, 50);

		write_pool_size($urandom_range(65536, 131071));
		queue_churn(100, 128, 55);

		// last stretch runs without idling
		pool_n = $urandom_range(1, 200);
		write_pool_size(pool_n);
		gaps_on = 1'b0;
		queue_churn(60, pool_n + 2, 50);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (outcomes_due.size() != 0)
			note_failure($sformatf("%0d result(s) never arrived", outcomes_due.size()));
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
